// ===== rtl/core/sparse_cartesian_product_scatter_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sparse Cartesian product scatter block
// Shorthand for clocked implication checks that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_CARTESIAN_PRODUCT_SCATTER_TOP_MACROS_SVH
`define SPARSE_CARTESIAN_PRODUCT_SCATTER_TOP_MACROS_SVH

// Same-cycle implication.
`define SCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/scp_pkg.sv =====
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants, types and tables of the sparse Cartesian product scatter.
// ----------------------------------------------------------------------------
package scp_pkg;

  // Block configuration.
  localparam int FEATURE_LANES = 4;
  localparam int WEIGHT_LANES  = 4;
  localparam int KERNEL        = 3;
  localparam int CHUNK         = 8;
  localparam int GRID          = 4;
  localparam int OUT_CHANNELS  = 64;

  // Field widths fixed by the channel format.
  localparam int MODE_W     = 2;
  localparam int PACK_LANES = 4;
  localparam int VAL_W      = 16;
  localparam int RUN_W      = 4;
  localparam int PACK_VW    = PACK_LANES * VAL_W;
  localparam int PACK_RW    = PACK_LANES * RUN_W;
  localparam int DEST_W     = 4;
  localparam int OCH_W      = 6;
  localparam int RC_OUT_W   = 3;
  localparam int BASE_W     = 16;
  localparam int SPAN_W     = 8;
  localparam int PE_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam int NUM_PAIRS = FEATURE_LANES * WEIGHT_LANES;
  localparam int KK        = KERNEL * KERNEL;
  localparam int HALF      = KERNEL / 2;

  // Absolute positions: 16-bit base plus up to four runs of sixteen.
  localparam int POS_W   = 17;
  localparam int WPOS_W  = $clog2(WEIGHT_LANES * (2 ** RUN_W) + 1);
  localparam int FSPAN_W = $clog2(FEATURE_LANES * (2 ** RUN_W) + 1);

  // Weight position split into channel and kernel offset. Positions at or
  // above CH_LIMIT map past the last channel, so only NW bits get divided.
  localparam int CH_LIMIT = OUT_CHANNELS * KK;
  localparam int NW       = $clog2(CH_LIMIT + 1);
  localparam int RK_SHIFT = $clog2(CH_LIMIT * KK) + 1;
  localparam int RK       = (2 ** RK_SHIFT + KK - 1) / KK;
  localparam int RK_W     = $clog2(RK + 1);
  localparam int QK_W     = $clog2(OUT_CHANNELS + 1);
  localparam int KM_W     = (NW + RK_W > RK_SHIFT + QK_W) ? NW + RK_W : RK_SHIFT + QK_W;

  // Feature position split into chunk row and column. Rows this far out are
  // beyond the neighbor chunk for any kernel offset and are dropped.
  localparam int F_LIMIT  = (2 * CHUNK + KERNEL) * CHUNK;
  localparam int FN_W     = $clog2(F_LIMIT + 1);
  localparam int RC_SHIFT = $clog2(F_LIMIT * CHUNK) + 1;
  localparam int RC       = (2 ** RC_SHIFT + CHUNK - 1) / CHUNK;
  localparam int RC_W     = $clog2(RC + 1);
  localparam int QC_W     = $clog2(2 * CHUNK + KERNEL + 1);
  localparam int CM_W     = (FN_W + RC_W > RC_SHIFT + QC_W) ? FN_W + RC_W : RC_SHIFT + QC_W;

  localparam int OFF_W   = (KK > 1) ? $clog2(KK) : 1;
  localparam int KO_W    = $clog2(HALF + 1) + 1;
  localparam int FCOL_W  = $clog2(CHUNK);
  localparam int XY_W    = QC_W + 2;
  localparam int ID_W    = 6;
  localparam int DEST_FW = 2 * ID_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_COMPUTE = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_RESTART = 2'd2
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_PE_ROW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PE_COL = 1'b1;

  typedef struct packed {
    logic [DEST_W-1:0]      dest_pe;
    logic [OCH_W-1:0]       out_channel;
    logic [RC_OUT_W-1:0]    out_row;
    logic [RC_OUT_W-1:0]    out_col;
    logic signed [VAL_W-1:0] product;
  } pair_t;

  typedef struct packed {
    pair_t pair;
    logic  last;
  } result_t;

  // Load enables of the four lane pipeline stages.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ctrl_t;

  typedef logic [KK-1:0][KO_W-1:0] ktab_t;

  function automatic ktab_t make_kcol();
    ktab_t t;
    for (int i = 0; i < KK; i++) begin
      t[i] = KO_W'(i % KERNEL - HALF);
    end
    return t;
  endfunction

  function automatic ktab_t make_krow();
    ktab_t t;
    for (int i = 0; i < KK; i++) begin
      t[i] = KO_W'(i / KERNEL - HALF);
    end
    return t;
  endfunction

  // Kernel column and row offset, centered, for each kernel position.
  localparam ktab_t KCOL = make_kcol();
  localparam ktab_t KROW = make_krow();

endpackage

// ===== rtl/core/scp_intf.sv =====
// ----------------------------------------------------------------------------
// scp_in_if / scp_out_if
// Valid/ready channels for compute items and for routed products.
// ----------------------------------------------------------------------------
interface scp_in_if import scp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [PACK_VW-1:0] weight_values;
  logic [PACK_RW-1:0] weight_runs;
  logic [PACK_VW-1:0] feature_values;
  logic [PACK_RW-1:0] feature_runs;

  modport source (
    output valid, mode, weight_values, weight_runs, feature_values, feature_runs,
    input  ready
  );
  modport sink (
    input  valid, mode, weight_values, weight_runs, feature_values, feature_runs,
    output ready
  );
endinterface

interface scp_out_if import scp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DEST_W-1:0]       dest_pe;
  logic [OCH_W-1:0]        out_channel;
  logic [RC_OUT_W-1:0]     out_row;
  logic [RC_OUT_W-1:0]     out_col;
  logic signed [VAL_W-1:0] product;
  logic                    last;

  modport source (
    output valid, dest_pe, out_channel, out_row, out_col, product, last,
    input  ready
  );
  modport sink (
    input  valid, dest_pe, out_channel, out_row, out_col, product, last,
    output ready
  );
endinterface

// ===== rtl/core/scp_lane.sv =====
// ----------------------------------------------------------------------------
// scp_lane
// One feature/weight pair: product, channel and kernel split, halo routing.
// ----------------------------------------------------------------------------
module scp_lane import scp_pkg::*; (
  input  logic                    clk_i,
  input  pipe_ctrl_t              ctrl_i,
  input  logic signed [VAL_W-1:0] w_i,
  input  logic signed [VAL_W-1:0] f_i,
  input  logic [POS_W-1:0]        wabs_i,
  input  logic [POS_W-1:0]        fabs_i,
  input  logic [PE_W-1:0]         pe_row_i,
  input  logic [PE_W-1:0]         pe_col_i,
  output logic                    vld_o,
  output pair_t                   pair_o
);

  localparam logic signed [XY_W-1:0] CHUNK_XY     = XY_W'(CHUNK);
  localparam logic signed [XY_W-1:0] TWO_CHUNK_XY = XY_W'(2 * CHUNK);
  localparam logic signed [ID_W-1:0] GRID_ID      = ID_W'(GRID);

  // Stage 1: captured operands.
  logic signed [VAL_W-1:0] w_q, f_q;
  logic [POS_W-1:0]        wabs_q, fabs_q;

  // Stage 2: multiplications.
  logic signed [2*VAL_W-1:0] prod_full;
  logic [KM_W-1:0]           kmul;
  logic [CM_W-1:0]           cmul;
  logic [VAL_W-1:0]          prod2_q;
  logic                      nz2_q, wok2_q, fok2_q;
  logic [NW-1:0]             n2_q;
  logic [FN_W-1:0]           fn2_q;
  logic [QK_W-1:0]           qk2_q;
  logic [QC_W-1:0]           qc2_q;

  // Stage 3: remainders.
  logic [NW-1:0]    off_full;
  logic [FN_W-1:0]  fcol_full;
  logic [OFF_W-1:0] off3_q;
  logic [FCOL_W-1:0] fcol3_q;
  logic [QK_W-1:0]  qk3_q;
  logic [QC_W-1:0]  qc3_q;
  logic [VAL_W-1:0] prod3_q;
  logic             ok3_q;

  // Stage 4: routing.
  logic signed [KO_W-1:0] wcol, wrow;
  logic signed [XY_W-1:0] x, y, xw, yw;
  logic signed [ID_W-1:0] col_id, row_id;
  logic                   col_ok, row_ok, y_ok;
  logic [DEST_FW-1:0]     dest_full;
  logic                   vld_q;
  pair_t                  pair_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      w_q    <= w_i;
      f_q    <= f_i;
      wabs_q <= wabs_i;
      fabs_q <= fabs_i;
    end
  end

  assign prod_full = w_q * f_q;
  assign kmul      = KM_W'(wabs_q[NW-1:0]) * KM_W'(RK);
  assign cmul      = CM_W'(fabs_q[FN_W-1:0]) * CM_W'(RC);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld2) begin
      prod2_q <= prod_full[VAL_W-1:0];
      nz2_q   <= (w_q != '0) && (f_q != '0);
      wok2_q  <= wabs_q < POS_W'(CH_LIMIT);
      fok2_q  <= fabs_q < POS_W'(F_LIMIT);
      n2_q    <= wabs_q[NW-1:0];
      fn2_q   <= fabs_q[FN_W-1:0];
      qk2_q   <= kmul[RK_SHIFT +: QK_W];
      qc2_q   <= cmul[RC_SHIFT +: QC_W];
    end
  end

  assign off_full  = n2_q - NW'(NW'(qk2_q) * NW'(KK));
  assign fcol_full = fn2_q - FN_W'(FN_W'(qc2_q) * FN_W'(CHUNK));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld3) begin
      off3_q  <= off_full[OFF_W-1:0];
      fcol3_q <= fcol_full[FCOL_W-1:0];
      qk3_q   <= qk2_q;
      qc3_q   <= qc2_q;
      prod3_q <= prod2_q;
      ok3_q   <= nz2_q && wok2_q && fok2_q;
    end
  end

  always_comb begin
    wcol = $signed(KCOL[off3_q]);
    wrow = $signed(KROW[off3_q]);
    x    = $signed({{(XY_W-FCOL_W){1'b0}}, fcol3_q}) - XY_W'(wcol);
    y    = $signed({{(XY_W-QC_W){1'b0}}, qc3_q}) - XY_W'(wrow);

    col_id = $signed({{(ID_W-PE_W){1'b0}}, pe_col_i});
    if (x < 0) begin
      col_id = col_id - ID_W'(1);
    end else if (x >= CHUNK_XY) begin
      col_id = col_id + ID_W'(1);
    end
    row_id = $signed({{(ID_W-PE_W){1'b0}}, pe_row_i});
    if (y < 0) begin
      row_id = row_id - ID_W'(1);
    end else if (y >= CHUNK_XY) begin
      row_id = row_id + ID_W'(1);
    end

    col_ok = (col_id >= 0) && (col_id < GRID_ID);
    row_ok = (row_id >= 0) && (row_id < GRID_ID);
    y_ok   = y < TWO_CHUNK_XY;

    // Wrap into the destination chunk; the halo reaches one chunk at most.
    if (x < 0) begin
      xw = x + CHUNK_XY;
    end else if (x >= CHUNK_XY) begin
      xw = x - CHUNK_XY;
    end else begin
      xw = x;
    end
    if (y < 0) begin
      yw = y + CHUNK_XY;
    end else if (y >= CHUNK_XY) begin
      yw = y - CHUNK_XY;
    end else begin
      yw = y;
    end

    dest_full = DEST_FW'(row_id) * DEST_FW'(GRID) + DEST_FW'(col_id);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld4) begin
      vld_q              <= ok3_q && col_ok && row_ok && y_ok;
      pair_q.dest_pe     <= dest_full[DEST_W-1:0];
      pair_q.out_channel <= OCH_W'(qk3_q);
      pair_q.out_row     <= yw[RC_OUT_W-1:0];
      pair_q.out_col     <= xw[RC_OUT_W-1:0];
      pair_q.product     <= $signed(prod3_q);
    end
  end

  assign vld_o  = vld_q;
  assign pair_o = pair_q;

endmodule

// ===== rtl/core/scp_merge.sv =====
// ----------------------------------------------------------------------------
// scp_merge
// Collects the routed pairs of one item and sends them out one per beat.
// ----------------------------------------------------------------------------
module scp_merge import scp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ld_i,
  input  logic [NUM_PAIRS-1:0] vld_i,
  input  pair_t                pair_i [NUM_PAIRS],
  output logic                 rdy_o,
  scp_out_if.source            out_o
);

  logic [NUM_PAIRS-1:0] mask_q, mask_d;
  logic [NUM_PAIRS-1:0] sel, rest;
  pair_t                data_q [NUM_PAIRS];
  pair_t                pick;
  logic                 pop;
  logic                 out_v_q, out_v_d;
  result_t              out_q;

  // Lowest pending pair first keeps the feature-major order.
  assign sel  = mask_q & (~mask_q + NUM_PAIRS'(1));
  assign rest = mask_q & ~sel;
  assign pop  = (mask_q != '0) && (!out_v_q || out_o.ready);

  always_comb begin
    pick = '0;
    for (int p = 0; p < NUM_PAIRS; p++) begin
      if (sel[p]) begin
        pick = pair_t'(pick | data_q[p]);
      end
    end
  end

  assign rdy_o = (mask_q == '0) || (pop && (rest == '0));

  always_comb begin
    mask_d = mask_q;
    if (ld_i) begin
      mask_d = vld_i;
    end else if (pop) begin
      mask_d = rest;
    end
    out_v_d = out_v_q;
    if (pop) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        data_q[p] <= pair_i[p];
      end
    end
    if (pop) begin
      out_q.pair <= pick;
      out_q.last <= (rest == '0);
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.dest_pe     = out_q.pair.dest_pe;
  assign out_o.out_channel = out_q.pair.out_channel;
  assign out_o.out_row     = out_q.pair.out_row;
  assign out_o.out_col     = out_q.pair.out_col;
  assign out_o.product     = out_q.pair.product;
  assign out_o.last        = out_q.last;

endmodule

// ===== rtl/core/sparse_cartesian_product_scatter_top.sv =====
// ----------------------------------------------------------------------------
// sparse_cartesian_product_scatter_top
// Sparse convolution element: Cartesian product of stored features and
// incoming weights, routed to the destination element of the grid.
//
// in_i takes one item per beat. Mode compute multiplies the weights with the
// stored feature vector; mode load replaces the feature vector; mode restart
// starts a new input channel. Load and restart only update the stored state
// and unused modes nothing; these are taken one per cycle while in_i.ready is
// high. Each compute item enters a four-stage pipeline of sixteen pair lanes,
// then a merge buffer that sends its routed pairs on out_o in feature-major
// order, one per beat, with last set on the final one. The first product
// passes the four lane stages, the merge buffer and the output register
// before it appears on out_o. A compute item holds the merge buffer until
// all of its routed pairs have left it. When out_o stalls the output register
// holds, the merge buffer and lane stages fill behind it and in_i.ready drops
// once all are full. pe_row and pe_col are written on the cfg port; the user
// must write them only while the block is idle, which the block does not
// enforce. Reset empties the pipeline and clears stores, positions, config.
// ----------------------------------------------------------------------------
`include "sparse_cartesian_product_scatter_top_macros.svh"

module sparse_cartesian_product_scatter_top import scp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  scp_in_if.sink                in_i,
  scp_out_if.source             out_o
);

  logic [PE_W-1:0] pe_row_q, pe_row_d, pe_col_q, pe_col_d;

  logic signed [VAL_W-1:0] feature_store_q [FEATURE_LANES];
  logic signed [VAL_W-1:0] feature_store_d [FEATURE_LANES];
  logic [RUN_W-1:0]        feature_run_store_q [FEATURE_LANES];
  logic [RUN_W-1:0]        feature_run_store_d [FEATURE_LANES];
  logic [BASE_W-1:0]       weight_base_q, weight_base_d;
  logic [BASE_W-1:0]       feature_base_q, feature_base_d;
  logic [SPAN_W-1:0]       feature_span_q, feature_span_d;

  logic signed [VAL_W-1:0] in_w [WEIGHT_LANES];
  logic [RUN_W-1:0]        in_wrun [WEIGHT_LANES];
  logic signed [VAL_W-1:0] in_f [FEATURE_LANES];
  logic [RUN_W-1:0]        in_frun [FEATURE_LANES];

  logic [WPOS_W-1:0]  wpos [WEIGHT_LANES];
  logic [FSPAN_W-1:0] span [FEATURE_LANES];
  logic [POS_W-1:0]   wabs [WEIGHT_LANES];
  logic [POS_W-1:0]   fabs [FEATURE_LANES];

  mode_e      in_mode;
  logic       in_acc;
  pipe_ctrl_t ctrl;
  logic       s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic       s1_free, s2_free, s3_free, s4_free, s4_go;
  logic       mrg_rdy;

  logic [NUM_PAIRS-1:0] lane_vld;
  pair_t                lane_pair [NUM_PAIRS];

  // Configuration.
  always_comb begin
    pe_row_d = pe_row_q;
    pe_col_d = pe_col_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PE_ROW: pe_row_d = cfg_data_i;
        CFG_PE_COL: pe_col_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack lanes; lanes past the packed four read as zero.
  for (genvar j = 0; j < WEIGHT_LANES; j++) begin : g_wunpack
    if (j < PACK_LANES) begin : g_packed
      assign in_w[j]    = $signed(in_i.weight_values[VAL_W*j +: VAL_W]);
      assign in_wrun[j] = in_i.weight_runs[RUN_W*j +: RUN_W];
    end else begin : g_extra
      assign in_w[j]    = '0;
      assign in_wrun[j] = '0;
    end
  end

  for (genvar i = 0; i < FEATURE_LANES; i++) begin : g_funpack
    if (i < PACK_LANES) begin : g_packed
      assign in_f[i]    = $signed(in_i.feature_values[VAL_W*i +: VAL_W]);
      assign in_frun[i] = in_i.feature_runs[RUN_W*i +: RUN_W];
    end else begin : g_extra
      assign in_f[i]    = '0;
      assign in_frun[i] = '0;
    end
  end

  // Running positions: each element advances past its zero run and itself.
  always_comb begin
    logic [WPOS_W-1:0]  wacc;
    logic [FSPAN_W-1:0] facc;
    wacc = '0;
    for (int j = 0; j < WEIGHT_LANES; j++) begin
      wacc    = wacc + WPOS_W'(in_wrun[j]) + WPOS_W'(1);
      wpos[j] = wacc;
      wabs[j] = POS_W'(weight_base_q) + POS_W'(wacc) - POS_W'(1);
    end
    facc = '0;
    for (int i = 0; i < FEATURE_LANES; i++) begin
      facc    = facc + FSPAN_W'(feature_run_store_q[i]) + FSPAN_W'(1);
      span[i] = facc;
      fabs[i] = POS_W'(feature_base_q) + POS_W'(facc) - POS_W'(1);
    end
  end

  assign in_mode = mode_e'(in_i.mode);
  assign in_acc  = in_i.valid && in_i.ready;

  always_comb begin
    weight_base_d  = weight_base_q;
    feature_base_d = feature_base_q;
    feature_span_d = feature_span_q;
    feature_store_d     = feature_store_q;
    feature_run_store_d = feature_run_store_q;
    if (in_acc) begin
      unique case (in_mode)
        MODE_COMPUTE: begin
          weight_base_d  = weight_base_q + BASE_W'(wpos[WEIGHT_LANES-1]);
          feature_span_d = SPAN_W'(span[FEATURE_LANES-1]);
        end
        MODE_LOAD: begin
          feature_base_d      = feature_base_q + BASE_W'(feature_span_q);
          feature_span_d      = '0;
          weight_base_d       = '0;
          feature_store_d     = in_f;
          feature_run_store_d = in_frun;
        end
        MODE_RESTART: begin
          weight_base_d  = '0;
          feature_base_d = '0;
          feature_span_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pe_row_q       <= '0;
      pe_col_q       <= '0;
      weight_base_q  <= '0;
      feature_base_q <= '0;
      feature_span_q <= '0;
      for (int i = 0; i < FEATURE_LANES; i++) begin
        feature_store_q[i]     <= '0;
        feature_run_store_q[i] <= '0;
      end
    end else begin
      pe_row_q            <= pe_row_d;
      pe_col_q            <= pe_col_d;
      weight_base_q       <= weight_base_d;
      feature_base_q      <= feature_base_d;
      feature_span_q      <= feature_span_d;
      feature_store_q     <= feature_store_d;
      feature_run_store_q <= feature_run_store_d;
    end
  end

  // Lane pipeline flow control: a stage moves on when the next one is free.
  assign s4_go   = s4_v_q && mrg_rdy;
  assign s4_free = !s4_v_q || s4_go;
  assign ctrl.ld4 = s3_v_q && s4_free;
  assign s3_free = !s3_v_q || ctrl.ld4;
  assign ctrl.ld3 = s2_v_q && s3_free;
  assign s2_free = !s2_v_q || ctrl.ld3;
  assign ctrl.ld2 = s1_v_q && s2_free;
  assign s1_free = !s1_v_q || ctrl.ld2;
  assign ctrl.ld1 = in_acc && (in_mode == MODE_COMPUTE);

  assign in_i.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= ctrl.ld1 || (s1_v_q && !ctrl.ld2);
      s2_v_q <= ctrl.ld2 || (s2_v_q && !ctrl.ld3);
      s3_v_q <= ctrl.ld3 || (s3_v_q && !ctrl.ld4);
      s4_v_q <= ctrl.ld4 || (s4_v_q && !s4_go);
    end
  end

  for (genvar i = 0; i < FEATURE_LANES; i++) begin : g_frow
    for (genvar j = 0; j < WEIGHT_LANES; j++) begin : g_wcol
      scp_lane u_lane (
        .clk_i    (clk_i),
        .ctrl_i   (ctrl),
        .w_i      (in_w[j]),
        .f_i      (feature_store_q[i]),
        .wabs_i   (wabs[j]),
        .fabs_i   (fabs[i]),
        .pe_row_i (pe_row_q),
        .pe_col_i (pe_col_q),
        .vld_o    (lane_vld[i*WEIGHT_LANES+j]),
        .pair_o   (lane_pair[i*WEIGHT_LANES+j])
      );
    end
  end

  scp_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (s4_go),
    .vld_i  (lane_vld),
    .pair_i (lane_pair),
    .rdy_o  (mrg_rdy),
    .out_o  (out_o)
  );

  `SCP_ASSERT_IMP(a_s1_from_compute, $rose(s1_v_q), $past(ctrl.ld1), "lane stage filled without a compute beat")
  `SCP_ASSERT_NXT(a_load_clears, in_acc && (in_mode == MODE_LOAD), (weight_base_q == '0) && (feature_span_q == '0), "feature load did not clear weight position")
  `SCP_ASSERT_IMP(a_full_stall, s1_v_q && s2_v_q && s3_v_q && s4_v_q && !mrg_rdy, !in_i.ready, "input ready while the lane pipeline is full and stalled")

endmodule

// ===== tb/tb_sparse_cartesian_product_scatter_top.sv =====
// ----------------------------------------------------------------------------
// tb_sparse_cartesian_product_scatter_top
// Drives compute, load, restart and unused-mode items into the scatter block.
// A behavioral predictor of the position decode and grid routing builds the
// expected products, and each product beat is compared in order. Random
// idling runs on both channels, and the element position moves between
// phases.
// ----------------------------------------------------------------------------
module tb_sparse_cartesian_product_scatter_top;
  import scp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PACK_VW-1:0] wv;
    logic [PACK_RW-1:0] wr;
    logic [PACK_VW-1:0] fv;
    logic [PACK_RW-1:0] fr;
  } pe_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  scp_in_if in_if ();
  scp_out_if out_if ();

  sparse_cartesian_product_scatter_top dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #10 clk = ~clk;

  // Predictor state.
  logic signed [VAL_W-1:0] feat_val [FEATURE_LANES];
  logic [RUN_W-1:0]        feat_run [FEATURE_LANES];
  logic [BASE_W-1:0]       w_base;
  logic [BASE_W-1:0]       f_base;
  logic [SPAN_W-1:0]       f_span;
  logic [PE_W-1:0]         elem_row;
  logic [PE_W-1:0]         elem_col;

  result_t routed_q [$];

  int send_idle = 0;
  int recv_idle = 0;
  int errors = 0;
  int items_sent = 0;
  int computes_sent = 0;
  int results_checked = 0;
  int positions_used = 0;
  int cycles = 0;

  // Computes the routed products of one accepted item and updates the state.
  task automatic route_item(input pe_item_t it);
    int unsigned span, wstep, fpos, wabs, offs, chan;
    int kcol, krow, x, y, col_id, row_id, first;
    logic signed [VAL_W-1:0] w, f;
    result_t r;
    first = routed_q.size();
    case (it.mode)
      MODE_LOAD: begin
        f_base = f_base + f_span;
        f_span = '0;
        w_base = '0;
        for (int i = 0; i < FEATURE_LANES; i++) begin
          feat_val[i] = it.fv[VAL_W*i +: VAL_W];
          feat_run[i] = it.fr[RUN_W*i +: RUN_W];
        end
      end
      MODE_RESTART: begin
        w_base = '0;
        f_base = '0;
        f_span = '0;
      end
      MODE_COMPUTE: begin
        span = 0;
        wstep = 0;
        for (int i = 0; i < FEATURE_LANES; i++) begin
          f = feat_val[i];
          span += feat_run[i] + 1;
          fpos = f_base + span - 1;
          wstep = 0;
          for (int j = 0; j < WEIGHT_LANES; j++) begin
            w = it.wv[VAL_W*j +: VAL_W];
            wstep += it.wr[RUN_W*j +: RUN_W] + 1;
            if (w == 0 || f == 0) continue;
            wabs = w_base + wstep - 1;
            offs = wabs % KK;
            chan = wabs / KK;
            if (chan >= OUT_CHANNELS) continue;
            kcol = int'(offs % KERNEL) - HALF;
            krow = int'(offs / KERNEL) - HALF;
            x = int'(fpos % CHUNK) - kcol;
            y = int'(fpos / CHUNK) - krow;
            col_id = elem_col;
            row_id = elem_row;
            if (x < 0) col_id -= 1;
            else if (x >= CHUNK) col_id += 1;
            if (col_id < 0 || col_id >= GRID) continue;
            // Rows beyond the neighbor chunk have no destination.
            if (y >= 2 * CHUNK) continue;
            if (y < 0) row_id -= 1;
            else if (y >= CHUNK) row_id += 1;
            if (row_id < 0 || row_id >= GRID) continue;
            x = (x + CHUNK) % CHUNK;
            y = (y + CHUNK) % CHUNK;
            r.pair.dest_pe     = DEST_W'(row_id * GRID + col_id);
            r.pair.out_channel = OCH_W'(chan);
            r.pair.out_row     = RC_OUT_W'(y);
            r.pair.out_col     = RC_OUT_W'(x);
            r.pair.product     = w * f;
            r.last             = 1'b0;
            routed_q.push_back(r);
          end
        end
        f_span = span[SPAN_W-1:0];
        w_base = w_base + wstep[BASE_W-1:0];
      end
      default: ;
    endcase
    if (routed_q.size() > first) routed_q[routed_q.size()-1].last = 1'b1;
  endtask

  function automatic pe_item_t make_item(input logic [MODE_W-1:0] mode,
                                         input logic [PACK_VW-1:0] wv,
                                         input logic [PACK_RW-1:0] wr,
                                         input logic [PACK_VW-1:0] fv,
                                         input logic [PACK_RW-1:0] fr);
    pe_item_t it;
    it.mode = mode;
    it.wv = wv;
    it.wr = wr;
    it.fv = fv;
    it.fr = fr;
    return it;
  endfunction

  // Lane values lean toward zero and the signed extremes.
  function automatic logic [PACK_VW-1:0] rand_values();
    logic [PACK_VW-1:0] v;
    for (int i = 0; i < PACK_LANES; i++) begin
      case ($urandom_range(9))
        0: v[VAL_W*i +: VAL_W] = 16'h0000;
        1: v[VAL_W*i +: VAL_W] = 16'h8000;
        2: v[VAL_W*i +: VAL_W] = 16'h7FFF;
        3: v[VAL_W*i +: VAL_W] = 16'hFFFF;
        default: v[VAL_W*i +: VAL_W] = VAL_W'($urandom);
      endcase
    end
    return v;
  endfunction

  // Mostly short runs so that positions stay inside the grid for a while.
  function automatic logic [PACK_RW-1:0] rand_runs();
    logic [PACK_RW-1:0] v;
    for (int i = 0; i < PACK_LANES; i++) begin
      if ($urandom_range(3) == 0) v[RUN_W*i +: RUN_W] = RUN_W'($urandom);
      else v[RUN_W*i +: RUN_W] = RUN_W'($urandom_range(2));
    end
    return v;
  endfunction

  function automatic logic [PACK_VW-1:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  // Sends one beat on the input channel; returns at the accepting edge.
  task automatic send_item(input pe_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.mode           <= it.mode;
    in_if.weight_values  <= it.wv;
    in_if.weight_runs    <= it.wr;
    in_if.feature_values <= it.fv;
    in_if.feature_runs   <= it.fr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    route_item(it);
    items_sent++;
    if (it.mode == MODE_COMPUTE) computes_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_if.valid <= 1'b0;
  endtask

  // Zero-result computes may still be in flight when the queue empties.
  task automatic wait_results_drained();
    stop_sending();
    while (routed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic place_element(input logic [PE_W-1:0] row, input logic [PE_W-1:0] col);
    wait_results_drained();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_PE_ROW;
    cfg_data <= row;
    @(negedge clk);
    cfg_idx  <= CFG_PE_COL;
    cfg_data <= col;
    @(negedge clk);
    cfg_we   <= 1'b0;
    elem_row = row;
    elem_col = col;
    positions_used++;
  endtask

  task automatic test_directed_items();
    send_item(make_item(MODE_RESTART, '0, '0, '0, '0));
    send_item(make_item(MODE_LOAD, '0, '0,
                        {16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF}, 16'h0000));
    send_item(make_item(MODE_COMPUTE, {16'h0002, 16'hFFFF, 16'h7FFF, 16'h8000},
                        16'h0000, '0, '0));
    // Zero weights give no product but still advance the positions.
    send_item(make_item(MODE_COMPUTE, {16'hFFF9, 16'h0000, 16'h0005, 16'h0000},
                        16'h130F, '0, '0));
    send_item(make_item(MODE_LOAD, '0, '0,
                        {16'h7FFF, 16'hFFFD, 16'h0064, 16'h0000}, 16'hFFFF));
    send_item(make_item(MODE_COMPUTE, {16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF},
                        16'hFFFF, '0, '0));
    send_item(make_item(MODE_UNUSED, rand_wide(), 16'hA5C3, rand_wide(), 16'h5A3C));
    send_item(make_item(MODE_COMPUTE, {16'h0003, 16'h0004, 16'h0005, 16'h0006},
                        16'h1234, '0, '0));
    send_item(make_item(MODE_RESTART, '0, '0, '0, '0));
    send_item(make_item(MODE_COMPUTE, '0, 16'h0000, '0, '0));
    send_item(make_item(MODE_RESTART, '0, '0, '0, '0));
    // Push the weight position past the last output channel.
    repeat (10) begin
      send_item(make_item(MODE_COMPUTE, {16'h0101, 16'h0202, 16'h0303, 16'h0404},
                          16'hFFFF, '0, '0));
    end
    send_item(make_item(MODE_LOAD, '0, '0,
                        {16'h0011, 16'h0022, 16'h0033, 16'h0044}, 16'h2101));
    send_item(make_item(MODE_COMPUTE, {16'h1111, 16'h2222, 16'h3333, 16'h4444},
                        16'h0120, '0, '0));
  endtask

  // Well-formed restart/load/compute sequences with random content, plus noise.
  task automatic test_random_traffic(input int n_items);
    int start, choice;
    start = items_sent;
    while (items_sent - start < n_items) begin
      choice = $urandom_range(99);
      if (choice < 12) begin
        send_item(make_item(MODE_W'($urandom_range(3)), rand_wide(),
                            PACK_RW'($urandom), rand_wide(), PACK_RW'($urandom)));
      end else if (choice < 15) begin
        wait_results_drained();
      end else begin
        if ($urandom_range(2) == 0)
          send_item(make_item(MODE_RESTART, rand_wide(), PACK_RW'($urandom),
                              rand_wide(), PACK_RW'($urandom)));
        send_item(make_item(MODE_LOAD, rand_wide(), PACK_RW'($urandom),
                            rand_values(), rand_runs()));
        repeat ($urandom_range(1, 5)) begin
          send_item(make_item(MODE_COMPUTE, rand_values(), rand_runs(),
                              rand_wide(), PACK_RW'($urandom)));
        end
      end
    end
  endtask

  // Output ready, redrawn every cycle.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sparse_cartesian_product_scatter_top] ERROR");
      $finish;
    end
  end

  // Compares each product beat with the oldest expected one.
  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.pair.dest_pe     = out_if.dest_pe;
      got.pair.out_channel = out_if.out_channel;
      got.pair.out_row     = out_if.out_row;
      got.pair.out_col     = out_if.out_col;
      got.pair.product     = out_if.product;
      got.last             = out_if.last;
      results_checked++;
      if (routed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat dest %0d ch %0d row %0d col %0d prod %0d last %0d",
                 $time, got.pair.dest_pe, got.pair.out_channel, got.pair.out_row,
                 got.pair.out_col, got.pair.product, got.last);
      end else begin
        exp_r = routed_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          $display("%0t: mismatch expected dest %0d ch %0d row %0d col %0d prod %0d last %0d",
                   $time, exp_r.pair.dest_pe, exp_r.pair.out_channel, exp_r.pair.out_row,
                   exp_r.pair.out_col, exp_r.pair.product, exp_r.last);
          $display("%0t:          got dest %0d ch %0d row %0d col %0d prod %0d last %0d",
                   $time, got.pair.dest_pe, got.pair.out_channel, got.pair.out_row,
                   got.pair.out_col, got.pair.product, got.last);
        end
      end
    end
  end

  initial begin
    logic [PE_W-1:0] rows [4];
    logic [PE_W-1:0] cols [4];
    int k;
    rows = '{2'd0, 2'd3, 2'd0, 2'd3};
    cols = '{2'd0, 2'd3, 2'd3, 2'd0};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.weight_values = '0;
    in_if.weight_runs = '0;
    in_if.feature_values = '0;
    in_if.feature_runs = '0;
    for (int i = 0; i < FEATURE_LANES; i++) begin
      feat_val[i] = '0;
      feat_run[i] = '0;
    end
    w_base = '0;
    f_base = '0;
    f_span = '0;
    elem_row = '0;
    elem_col = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle = 33;
    recv_idle = 68;
    place_element(2'd1, 2'd2);
    test_directed_items();

    k = 0;
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 33 : (p == 1) ? 68 : 0;
      recv_idle = (p == 0) ? 68 : (p == 1) ? 33 : 0;
      for (int s = 0; s < 3; s++) begin
        if (k < 4) place_element(rows[k], cols[k]);
        else place_element(PE_W'($urandom), PE_W'($urandom));
        test_random_traffic(48);
        k++;
      end
    end

    wait_results_drained();
    repeat (20) @(posedge clk);
    $display("Checked %0d product beats from %0d items (%0d compute) at %0d positions,",
             results_checked, items_sent, computes_sent, positions_used);
    $display("with grid edges, dropped pairs, unused mode and channel overflow.");
    if (errors == 0 && routed_q.size() == 0) begin
      $display("[sparse_cartesian_product_scatter_top] OK");
    end else begin
      $display("[sparse_cartesian_product_scatter_top] ERROR");
    end
    $finish;
  end

endmodule
